// ===== rtl/five_bar_inverse_kinematics_macros.svh =====
// Assertion macros for the five-bar inverse kinematics block
`ifndef FIVE_BAR_INVERSE_KINEMATICS_MACROS_SVH
`define FIVE_BAR_INVERSE_KINEMATICS_MACROS_SVH

// condition checked at every clock edge out of reset
`define FBIK_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FBIK_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/fbik_pkg.sv =====
// Package for the five-bar inverse kinematics block: widths, codes, types, tables
`default_nettype none

package fbik_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int STEP_W        = 5;

   localparam int COORD_W  = 20;
   localparam int LINK_W   = 19;
   localparam int CSR_IDX_W = 3;
   localparam int DELTA_W  = 21;
   localparam int SQX_W    = 41;
   localparam int SQ_W     = 42;
   localparam int LSQ_W    = 38;
   localparam int NUM_W    = 44;

   localparam int RAD_W    = 62;
   localparam int ROOT_W   = 31;
   localparam int REM_W    = 32;
   localparam int SQRT_STEPS = ROOT_W;

   localparam int DIV_W    = 51;
   localparam int DEN_W    = 50;
   localparam int Q_W      = 31;
   localparam int DIV_STEPS = Q_W;
   localparam int QSQ_W    = 61;
   localparam int C_W      = 32;

   localparam int CV_W     = 44;
   localparam int ANG_W    = 26;
   localparam int SUM_W    = 27;
   localparam int OUT_W    = 16;
   localparam int ANGLE_SHIFT = 10;
   localparam int ANGLE_LIMIT = 23040;

   localparam logic [Q_W-1:0]   COS_ONE    = 31'd1073741824;
   localparam logic [Q_W-1:0]   COS_MAX    = 31'd1074278695;
   localparam logic [QSQ_W-1:0] COS_ONE_SQ = {1'b1, 60'd0};
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd5898240;

   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_ONE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_TWO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTAL_ONE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTAL_TWO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING    = 3'd4;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_M1_ZERO,
      STATUS_M1_UNREACH,
      STATUS_M2_ZERO,
      STATUS_M2_UNREACH
   } status_type;

   typedef enum logic [1:0] {
      SIDE_OK,
      SIDE_ZERO,
      SIDE_UNREACH
   } side_status_type;

   typedef struct packed {
      logic [LINK_W-1:0] crank;
      logic [LINK_W-1:0] distal;
   } link_cfg_type;

   typedef struct packed {
      logic                    valid;
      side_status_type         status;
      logic signed [ANG_W-1:0] beta;
      logic signed [ANG_W-1:0] alpha;
   } side_res_type;

   typedef struct packed {
      logic signed [CV_W-1:0]  x;
      logic signed [CV_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_vec_type;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [STEP_W-1:0] step);
      logic signed [ANG_W-1:0] val;
      case (step)
         5'd0:  val = 26'sd2949120;
         5'd1:  val = 26'sd1740967;
         5'd2:  val = 26'sd919879;
         5'd3:  val = 26'sd466945;
         5'd4:  val = 26'sd234379;
         5'd5:  val = 26'sd117304;
         5'd6:  val = 26'sd58666;
         5'd7:  val = 26'sd29335;
         5'd8:  val = 26'sd14668;
         5'd9:  val = 26'sd7334;
         5'd10: val = 26'sd3667;
         5'd11: val = 26'sd1833;
         5'd12: val = 26'sd917;
         5'd13: val = 26'sd458;
         5'd14: val = 26'sd229;
         5'd15: val = 26'sd115;
         5'd16: val = 26'sd57;
         5'd17: val = 26'sd29;
         5'd18: val = 26'sd14;
         5'd19: val = 26'sd7;
         5'd20: val = 26'sd4;
         5'd21: val = 26'sd2;
         5'd22: val = 26'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

   // fold the left half plane into the right one by a quarter turn
   function automatic cordic_vec_type cordic_prerotate(input logic signed [CV_W-1:0] y,
                                                       input logic signed [CV_W-1:0] x);
      cordic_vec_type v;
      v.x = x;
      v.y = y;
      v.z = '0;
      if (x[CV_W-1]) begin
         if (!y[CV_W-1]) begin
            v.x = y;
            v.y = -x;
            v.z = QUARTER_TURN;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -QUARTER_TURN;
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fbik_sqrt_cell.sv =====
// One digit of the pipelined integer square root
`default_nettype none

module fbik_sqrt_cell import fbik_pkg::*; (
   input  logic              clock,
   input  logic [RAD_W-1:0]  rad_i,
   input  logic [REM_W-1:0]  rem_i,
   input  logic [ROOT_W-1:0] root_i,
   output logic [RAD_W-1:0]  rad_o,
   output logic [REM_W-1:0]  rem_o,
   output logic [ROOT_W-1:0] root_o
);

   logic [RAD_W-1:0]  rad_in, rad_ff;
   logic [REM_W-1:0]  rem_in, rem_ff;
   logic [ROOT_W-1:0] root_in, root_ff;
   logic [REM_W+1:0]  rem_trial;
   logic [REM_W+1:0]  trial;
   logic              take;

   always_comb begin
      rem_trial = {rem_i, rad_i[RAD_W-1 -: 2]};
      trial     = {1'b0, root_i, 2'b01};
      take      = rem_trial >= trial;
      rem_in    = take ? REM_W'(rem_trial - trial) : REM_W'(rem_trial);
      root_in   = {root_i[ROOT_W-2:0], take};
      rad_in    = {rad_i[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

`default_nettype wire

// ===== rtl/fbik_div_cell.sv =====
// One quotient bit of the pipelined restoring divider
`default_nettype none

module fbik_div_cell import fbik_pkg::*; (
   input  logic             clock,
   input  logic [DIV_W-1:0] rem_i,
   input  logic [DEN_W-1:0] den_i,
   input  logic [Q_W-1:0]   q_i,
   output logic [DIV_W-1:0] rem_o,
   output logic [DEN_W-1:0] den_o,
   output logic [Q_W-1:0]   q_o
);

   logic [DIV_W-1:0] rem_in, rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   q_in, q_ff;
   logic [DIV_W-1:0] diff;
   logic [DIV_W-1:0] kept;
   logic             take;

   always_comb begin
      take   = rem_i >= {1'b0, den_i};
      diff   = rem_i - {1'b0, den_i};
      kept   = take ? diff : rem_i;
      rem_in = {kept[DIV_W-2:0], 1'b0};
      q_in   = {q_i[Q_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_i;
      q_ff   <= q_in;
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign q_o   = q_ff;

endmodule

`default_nettype wire

// ===== rtl/fbik_cordic_cell.sv =====
// One vectoring iteration of the pipelined CORDIC
`default_nettype none

module fbik_cordic_cell import fbik_pkg::*; (
   input  logic              clock,
   input  logic [STEP_W-1:0] step,
   input  cordic_vec_type    vec_i,
   output cordic_vec_type    vec_o
);

   cordic_vec_type          vec_in, vec_ff;
   logic signed [CV_W-1:0]  x_sh, y_sh;
   logic signed [ANG_W-1:0] angle;
   logic                    rotate_down;

   always_comb begin
      x_sh        = $signed(vec_i.x) >>> step;
      y_sh        = $signed(vec_i.y) >>> step;
      angle       = atan_lookup(step);
      rotate_down = !vec_i.y[CV_W-1] && (vec_i.y != '0);
      if (rotate_down) begin
         vec_in.x = vec_i.x + y_sh;
         vec_in.y = vec_i.y - x_sh;
         vec_in.z = vec_i.z + angle;
      end else begin
         vec_in.x = vec_i.x - y_sh;
         vec_in.y = vec_i.y + x_sh;
         vec_in.z = vec_i.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign vec_o = vec_ff;

endmodule

`default_nettype wire

// ===== rtl/fbik_side.sv =====
// One side of the linkage: radius, law of cosines, acos and atan2 as a cell chain
`default_nettype none

module fbik_side import fbik_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [DELTA_W-1:0] dx,
   input  logic signed [DELTA_W-1:0] dy,
   input  link_cfg_type              cfg,
   output side_res_type              res
);

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic                      zero;
      logic signed [NUM_W-1:0]   num;
   } carry_a_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic                      zero;
      logic                      neg;
      logic                      fail;
   } carry_b_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic                      zero;
      logic                      fail;
      logic signed [C_W-1:0]     c;
   } carry_c_type;

   // link squares follow the registers; the user must change those only while idle, the block does not check it
   logic [LSQ_W-1:0] crank_sq_ff, distal_sq_ff;

   always_ff @(posedge clock) begin
      crank_sq_ff  <= cfg.crank * cfg.crank;
      distal_sq_ff <= cfg.distal * cfg.distal;
   end

   // squares of the offsets
   logic                        p1_valid_ff;
   logic signed [DELTA_W-1:0]   p1_dx_ff, p1_dy_ff;
   logic [SQX_W-1:0]            p1_sqx_ff, p1_sqy_ff;
   logic signed [2*DELTA_W-1:0] prod_x, prod_y;

   assign prod_x = dx * dx;
   assign prod_y = dy * dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_dx_ff  <= dx;
      p1_dy_ff  <= dy;
      p1_sqx_ff <= prod_x[SQX_W-1:0];
      p1_sqy_ff <= prod_y[SQX_W-1:0];
   end

   logic                      p2_valid_ff;
   logic signed [DELTA_W-1:0] p2_dx_ff, p2_dy_ff;
   logic [SQ_W-1:0]           p2_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_dx_ff <= p1_dx_ff;
      p2_dy_ff <= p1_dy_ff;
      p2_r2_ff <= SQ_W'(p1_sqx_ff) + SQ_W'(p1_sqy_ff);
   end

   // radius with 8 extra fraction bits
   logic [RAD_W-1:0]  sa_rad  [SQRT_STEPS+1];
   logic [REM_W-1:0]  sa_rem  [SQRT_STEPS+1];
   logic [ROOT_W-1:0] sa_root [SQRT_STEPS+1];
   logic              va_ff   [SQRT_STEPS];
   carry_a_type       ca_ff   [SQRT_STEPS];
   carry_a_type       ca_head_in;

   assign sa_rad[0]  = {4'b0, p2_r2_ff, 16'b0};
   assign sa_rem[0]  = '0;
   assign sa_root[0] = '0;

   always_comb begin
      ca_head_in.dx   = p2_dx_ff;
      ca_head_in.dy   = p2_dy_ff;
      ca_head_in.zero = p2_r2_ff == '0;
      ca_head_in.num  = $signed({6'b0, crank_sq_ff}) + $signed({2'b0, p2_r2_ff})
                        - $signed({6'b0, distal_sq_ff});
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt_a
      fbik_sqrt_cell u_cell (
         .clock  (clock),
         .rad_i  (sa_rad[k]),
         .rem_i  (sa_rem[k]),
         .root_i (sa_root[k]),
         .rad_o  (sa_rad[k+1]),
         .rem_o  (sa_rem[k+1]),
         .root_o (sa_root[k+1])
      );
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               va_ff[k] <= 1'b0;
            end else begin
               va_ff[k] <= p2_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            ca_ff[k] <= ca_head_in;
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (reset) begin
               va_ff[k] <= 1'b0;
            end else begin
               va_ff[k] <= va_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            ca_ff[k] <= ca_ff[k-1];
         end
      end
   end

   // denominator 2*crank*r and numerator magnitude
   logic                      p3_valid_ff;
   logic signed [DELTA_W-1:0] p3_dx_ff, p3_dy_ff;
   logic                      p3_zero_ff, p3_neg_ff;
   logic [DIV_W-1:0]          p3_a_ff;
   logic [DEN_W-1:0]          p3_den_ff;
   logic [LINK_W+ROOT_W:0]    den_full;
   logic signed [NUM_W-1:0]   num_mag;
   carry_a_type               ca_last;

   assign ca_last  = ca_ff[SQRT_STEPS-1];
   assign den_full = {cfg.crank, 1'b0} * sa_root[SQRT_STEPS];
   assign num_mag  = ca_last.num[NUM_W-1] ? -ca_last.num : ca_last.num;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= va_ff[SQRT_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      p3_dx_ff   <= ca_last.dx;
      p3_dy_ff   <= ca_last.dy;
      p3_zero_ff <= ca_last.zero;
      p3_neg_ff  <= ca_last.num[NUM_W-1];
      p3_a_ff    <= {num_mag[DIV_W-9:0], 8'b0};
      p3_den_ff  <= den_full[DEN_W-1:0];
   end

   // cosine magnitude, Q30, bit by bit; a quotient of 2 or more fails
   logic [DIV_W-1:0] dv_rem [DIV_STEPS+1];
   logic [DEN_W-1:0] dv_den [DIV_STEPS+1];
   logic [Q_W-1:0]   dv_q   [DIV_STEPS+1];
   logic             vb_ff  [DIV_STEPS];
   carry_b_type      cb_ff  [DIV_STEPS];
   carry_b_type      cb_head_in;

   assign dv_rem[0] = p3_a_ff;
   assign dv_den[0] = p3_den_ff;
   assign dv_q[0]   = '0;

   always_comb begin
      cb_head_in.dx   = p3_dx_ff;
      cb_head_in.dy   = p3_dy_ff;
      cb_head_in.zero = p3_zero_ff;
      cb_head_in.neg  = p3_neg_ff;
      cb_head_in.fail = {1'b0, p3_a_ff} >= {1'b0, p3_den_ff, 1'b0};
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      fbik_div_cell u_cell (
         .clock (clock),
         .rem_i (dv_rem[k]),
         .den_i (dv_den[k]),
         .q_i   (dv_q[k]),
         .rem_o (dv_rem[k+1]),
         .den_o (dv_den[k+1]),
         .q_o   (dv_q[k+1])
      );
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               vb_ff[k] <= 1'b0;
            end else begin
               vb_ff[k] <= p3_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            cb_ff[k] <= cb_head_in;
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (reset) begin
               vb_ff[k] <= 1'b0;
            end else begin
               vb_ff[k] <= vb_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            cb_ff[k] <= cb_ff[k-1];
         end
      end
   end

   // tolerance check and clamp to one
   logic                      p5_valid_ff;
   carry_b_type               p5_carry_ff;
   logic [Q_W-1:0]            p5_qc_ff;
   logic [Q_W-1:0]            q_final;
   carry_b_type               cb_last;
   carry_b_type               p5_carry_in;

   assign q_final = dv_q[DIV_STEPS];
   assign cb_last = cb_ff[DIV_STEPS-1];

   always_comb begin
      p5_carry_in      = cb_last;
      p5_carry_in.fail = cb_last.fail || (q_final > COS_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else begin
         p5_valid_ff <= vb_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      p5_carry_ff <= p5_carry_in;
      p5_qc_ff    <= (q_final > COS_ONE) ? COS_ONE : q_final;
   end

   logic                p6_valid_ff;
   carry_b_type         p6_carry_ff;
   logic [Q_W-1:0]      p6_qc_ff;
   logic [QSQ_W-1:0]    p6_qsq_ff;
   logic [2*Q_W-1:0]    qsq_full;

   assign qsq_full = p5_qc_ff * p5_qc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else begin
         p6_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p6_carry_ff <= p5_carry_ff;
      p6_qc_ff    <= p5_qc_ff;
      p6_qsq_ff   <= qsq_full[QSQ_W-1:0];
   end

   // sine magnitude from sqrt(1 - c^2)
   logic [RAD_W-1:0]  sb_rad  [SQRT_STEPS+1];
   logic [REM_W-1:0]  sb_rem  [SQRT_STEPS+1];
   logic [ROOT_W-1:0] sb_root [SQRT_STEPS+1];
   logic              vc_ff   [SQRT_STEPS];
   carry_c_type       cc_ff   [SQRT_STEPS];
   carry_c_type       cc_head_in;
   logic signed [C_W-1:0] c_pos;

   assign sb_rad[0]  = {1'b0, COS_ONE_SQ - p6_qsq_ff};
   assign sb_rem[0]  = '0;
   assign sb_root[0] = '0;
   assign c_pos      = $signed({1'b0, p6_qc_ff});

   always_comb begin
      cc_head_in.dx   = p6_carry_ff.dx;
      cc_head_in.dy   = p6_carry_ff.dy;
      cc_head_in.zero = p6_carry_ff.zero;
      cc_head_in.fail = p6_carry_ff.fail;
      cc_head_in.c    = p6_carry_ff.neg ? -c_pos : c_pos;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt_b
      fbik_sqrt_cell u_cell (
         .clock  (clock),
         .rad_i  (sb_rad[k]),
         .rem_i  (sb_rem[k]),
         .root_i (sb_root[k]),
         .rad_o  (sb_rad[k+1]),
         .rem_o  (sb_rem[k+1]),
         .root_o (sb_root[k+1])
      );
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               vc_ff[k] <= 1'b0;
            end else begin
               vc_ff[k] <= p6_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            cc_ff[k] <= cc_head_in;
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (reset) begin
               vc_ff[k] <= 1'b0;
            end else begin
               vc_ff[k] <= vc_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            cc_ff[k] <= cc_ff[k-1];
         end
      end
   end

   // quadrant fold for both angle CORDICs
   logic                   p8_valid_ff;
   side_status_type        p8_status_ff;
   cordic_vec_type         p8_alpha_ff, p8_beta_ff;
   carry_c_type            cc_last;
   logic signed [CV_W-1:0] alpha_y, alpha_x, beta_y, beta_x;
   side_status_type        status_in;

   assign cc_last = cc_ff[SQRT_STEPS-1];

   always_comb begin
      alpha_y = $signed({3'b0, sb_root[SQRT_STEPS], 10'b0});
      alpha_x = CV_W'(cc_last.c) <<< 10;
      beta_y  = CV_W'(cc_last.dy) <<< 20;
      beta_x  = CV_W'(cc_last.dx) <<< 20;
      if (cc_last.zero) begin
         status_in = SIDE_ZERO;
      end else if (cc_last.fail) begin
         status_in = SIDE_UNREACH;
      end else begin
         status_in = SIDE_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p8_valid_ff <= 1'b0;
      end else begin
         p8_valid_ff <= vc_ff[SQRT_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      p8_status_ff <= status_in;
      p8_alpha_ff  <= cordic_prerotate(alpha_y, alpha_x);
      p8_beta_ff   <= cordic_prerotate(beta_y, beta_x);
   end

   cordic_vec_type  cr_alpha [CORDIC_STAGES+1];
   cordic_vec_type  cr_beta  [CORDIC_STAGES+1];
   logic            vd_ff    [CORDIC_STAGES];
   side_status_type sd_ff    [CORDIC_STAGES];

   assign cr_alpha[0] = p8_alpha_ff;
   assign cr_beta[0]  = p8_beta_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      fbik_cordic_cell u_alpha (
         .clock (clock),
         .step  (STEP_W'(k)),
         .vec_i (cr_alpha[k]),
         .vec_o (cr_alpha[k+1])
      );
      fbik_cordic_cell u_beta (
         .clock (clock),
         .step  (STEP_W'(k)),
         .vec_i (cr_beta[k]),
         .vec_o (cr_beta[k+1])
      );
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               vd_ff[k] <= 1'b0;
            end else begin
               vd_ff[k] <= p8_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            sd_ff[k] <= p8_status_ff;
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (reset) begin
               vd_ff[k] <= 1'b0;
            end else begin
               vd_ff[k] <= vd_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   always_comb begin
      res.valid  = vd_ff[CORDIC_STAGES-1];
      res.status = sd_ff[CORDIC_STAGES-1];
      res.beta   = cr_beta[CORDIC_STAGES].z;
      res.alpha  = cr_alpha[CORDIC_STAGES].z;
   end

endmodule

`default_nettype wire

// ===== rtl/five_bar_inverse_kinematics.sv =====
// Five-bar linkage inverse kinematics: a target point in, the two motor angles and a
// status out. An item is taken at every clock edge with start high; busy never rises.
// Each item runs down a fixed chain of registered cells (square root digits, divider
// bits and CORDIC iterations, both sides side by side) to the result register; a new
// item can be taken before the last is through; results leave in order, one per
// cycle at most. A result is shown for one cycle with rsp_valid high and cannot be
// held off, so the receiver must take it then. The user must write link registers
// through the csr_ port only while no item is in flight; the block does not check it.
`default_nettype none

`include "five_bar_inverse_kinematics_macros.svh"

module five_bar_inverse_kinematics import fbik_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_target_x,
   input  logic signed [COORD_W-1:0] req_target_y,
   output logic                      rsp_valid,
   output logic signed [OUT_W-1:0]   rsp_angle_one,
   output logic signed [OUT_W-1:0]   rsp_angle_two,
   output logic [2:0]                rsp_status,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [LINK_W-1:0]         csr_wdata
);

   logic [LINK_W-1:0] upper_one_ff, upper_two_ff;
   logic [LINK_W-1:0] distal_one_ff, distal_two_ff;
   logic [LINK_W-1:0] spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_one_ff  <= 19'd12800;
         upper_two_ff  <= 19'd12800;
         distal_one_ff <= 19'd19200;
         distal_two_ff <= 19'd19200;
         spacing_ff    <= 19'd6400;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UPPER_ONE:  upper_one_ff  <= csr_wdata;
            CSR_UPPER_TWO:  upper_two_ff  <= csr_wdata;
            CSR_DISTAL_ONE: distal_one_ff <= csr_wdata;
            CSR_DISTAL_TWO: distal_two_ff <= csr_wdata;
            CSR_SPACING:    spacing_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                      accept;
   logic signed [DELTA_W-1:0] dx_one, dx_two, dy_all;
   link_cfg_type              cfg_one, cfg_two;
   side_res_type              side_one_res, side_two_res;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign dx_one  = DELTA_W'(req_target_x);
   assign dx_two  = DELTA_W'(req_target_x) - $signed({2'b0, spacing_ff});
   assign dy_all  = DELTA_W'(req_target_y);

   always_comb begin
      cfg_one.crank  = upper_one_ff;
      cfg_one.distal = distal_one_ff;
      cfg_two.crank  = upper_two_ff;
      cfg_two.distal = distal_two_ff;
   end

   fbik_side u_side_one (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .dx       (dx_one),
      .dy       (dy_all),
      .cfg      (cfg_one),
      .res      (side_one_res)
   );

   fbik_side u_side_two (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .dx       (dx_two),
      .dy       (dy_all),
      .cfg      (cfg_two),
      .res      (side_two_res)
   );

   // round half up to 1/64 degree, then saturate
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v + SUM_W'(512)) >>> ANGLE_SHIFT;
      if (r > ANGLE_LIMIT) begin
         r = SUM_W'(ANGLE_LIMIT);
      end else if (r < -ANGLE_LIMIT) begin
         r = -SUM_W'(ANGLE_LIMIT);
      end
      return r[OUT_W-1:0];
   endfunction

   logic signed [SUM_W-1:0]  sum_one, sum_two;
   status_type               status_in;
   logic signed [OUT_W-1:0]  angle_one_in, angle_two_in;

   always_comb begin
      sum_one      = SUM_W'(side_one_res.beta) + SUM_W'(side_one_res.alpha);
      sum_two      = SUM_W'(side_two_res.beta) - SUM_W'(side_two_res.alpha);
      angle_one_in = '0;
      angle_two_in = '0;
      if (side_one_res.status != SIDE_OK) begin
         status_in = (side_one_res.status == SIDE_ZERO) ? STATUS_M1_ZERO : STATUS_M1_UNREACH;
      end else if (side_two_res.status != SIDE_OK) begin
         status_in = (side_two_res.status == SIDE_ZERO) ? STATUS_M2_ZERO : STATUS_M2_UNREACH;
      end else begin
         status_in    = STATUS_OK;
         angle_one_in = round_sat(sum_one);
         angle_two_in = round_sat(sum_two);
      end
   end

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] angle_one_ff, angle_two_ff;
   status_type              status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_one_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      angle_one_ff <= angle_one_in;
      angle_two_ff <= angle_two_in;
      status_ff    <= status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_one = angle_one_ff;
   assign rsp_angle_two = angle_two_ff;
   assign rsp_status    = status_ff;

   `FBIK_ASSERT_ALWAYS(sides_lockstep_a, side_one_res.valid == side_two_res.valid, "side pipelines out of step")
   `FBIK_ASSERT_IMPLY(fail_zero_angles_a, rsp_valid && (status_ff != STATUS_OK), (rsp_angle_one == '0) && (rsp_angle_two == '0), "nonzero angle on a failed transfer")
   `FBIK_ASSERT_IMPLY(angle_range_a, rsp_valid, (rsp_angle_one <= ANGLE_LIMIT) && (rsp_angle_one >= -ANGLE_LIMIT) && (rsp_angle_two <= ANGLE_LIMIT) && (rsp_angle_two >= -ANGLE_LIMIT), "angle beyond limit")
   `FBIK_ASSERT_IMPLY(m2_after_m1_a, rsp_valid && ((status_ff == STATUS_M2_ZERO) || (status_ff == STATUS_M2_UNREACH)), $past(side_one_res.status) == SIDE_OK, "motor 2 status with motor 1 failing")

endmodule

`default_nettype wire
